### rtl/prepaid_wallet_load_gate_top_defines.svh
// Assertion macros shared by the prepaid wallet load gate RTL.
`ifndef PREPAID_WALLET_LOAD_GATE_TOP_DEFINES_SVH
`define PREPAID_WALLET_LOAD_GATE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PWLG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PWLG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pwlg_pkg.sv
// Types, constants and helper functions for the prepaid wallet load gate.
`timescale 1ns / 1ps
`default_nettype none

package pwlg_pkg;

    localparam int LOADS       = 4;
    localparam int FIELD_LOADS = 4;
    localparam int LANES       = (LOADS < FIELD_LOADS) ? LOADS : FIELD_LOADS;

    localparam int BAL_W   = 40;
    localparam int POW_W   = 16;
    localparam int RATE_W  = 32;
    localparam int BAND_W  = 20;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = POW_W + RATE_W;
    localparam int SUM_W   = PROD_W + 3;
    localparam int COST_W  = SUM_W - FRAC_W;
    localparam int WIDE_W  = BAL_W + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RATE_W;

    localparam logic [BAND_W-1:0] ZERO_BAND_RESET = BAND_W'(125);

    localparam logic signed [WIDE_W-1:0] WIDE_BAL_MAX =
        {{(WIDE_W - BAL_W + 1){1'b0}}, {(BAL_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_BAL_MIN =
        {{(WIDE_W - BAL_W + 1){1'b1}}, {(BAL_W - 1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_TIMESTEP      = 2'd0,
        KIND_DAY_START     = 2'd1,
        KIND_SET_THRESHOLD = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE      = 1'd0,
        REG_ZERO_BAND = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [1:0]              load_index;
        logic signed [BAL_W-1:0] threshold_value;
        logic signed [BAL_W-1:0] real_delta;
        logic signed [BAL_W-1:0] virtual_delta;
        logic [FIELD_LOADS-1:0]  demand_mask;
        logic [POW_W-1:0]        power_0;
        logic [POW_W-1:0]        power_1;
        logic [POW_W-1:0]        power_2;
        logic [POW_W-1:0]        power_3;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_LOADS-1:0]  actuation_mask;
        logic signed [BAL_W-1:0] real_balance;
        logic signed [BAL_W-1:0] virtual_balance;
        logic                    shed_all;
    } out_word_t;

    // Balance update produced by the merge stage for one word.
    typedef struct packed {
        logic [FIELD_LOADS-1:0]  mask;
        logic signed [BAL_W-1:0] real_bal;
        logic signed [BAL_W-1:0] virt_bal;
        logic                    shed;
    } wallet_upd_t;

    function automatic logic signed [BAL_W-1:0] sat_bal(input logic signed [WIDE_W-1:0] v);
        logic signed [BAL_W-1:0] r;
        if (v > WIDE_BAL_MAX) begin
            r = WIDE_BAL_MAX[BAL_W-1:0];
        end else if (v < WIDE_BAL_MIN) begin
            r = WIDE_BAL_MIN[BAL_W-1:0];
        end else begin
            r = v[BAL_W-1:0];
        end
        return r;
    endfunction

    // Small negative balances inside the band are snapped to zero.
    function automatic logic signed [BAL_W-1:0] band_clear(
        input logic signed [BAL_W-1:0] v,
        input logic [BAND_W-1:0]       band
    );
        logic [BAL_W:0]          mag;
        logic signed [BAL_W-1:0] r;
        mag = (BAL_W + 1)'(-{v[BAL_W-1], v});
        r   = v;
        if (v[BAL_W-1] && (mag < {{(BAL_W + 1 - BAND_W){1'b0}}, band})) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/pwlg_lane.sv
// One load lane: registered power-times-rate product and the run decision.
`timescale 1ns / 1ps
`default_nettype none

module pwlg_lane (
    input  wire logic                             clk,
    input  wire logic                             load,
    input  wire logic [pwlg_pkg::POW_W-1:0]       power,
    input  wire logic [pwlg_pkg::RATE_W-1:0]      rate,
    input  wire logic                             demand,
    input  wire logic signed [pwlg_pkg::BAL_W-1:0] threshold,
    input  wire logic signed [pwlg_pkg::BAL_W-1:0] virt_bal,
    input  wire logic                             real_pos,
    output logic                                  on,
    output logic [pwlg_pkg::PROD_W-1:0]           gated_prod
);
    import pwlg_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // The product does not depend on the balances, so it is formed as the word
    // is accepted and registered along with it into the first stage.
    assign prod_next = PROD_W'(power) * PROD_W'(rate);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign on         = demand && (virt_bal >= threshold) && real_pos;
    assign gated_prod = on ? prod_reg : '0;

endmodule

`default_nettype wire

### rtl/pwlg_merge.sv
// Merge stage: sums lane costs and computes the new wallet balances.
`timescale 1ns / 1ps
`default_nettype none

module pwlg_merge (
    input  wire logic [1:0]                        kind,
    input  wire logic signed [pwlg_pkg::BAL_W-1:0] real_delta,
    input  wire logic signed [pwlg_pkg::BAL_W-1:0] virtual_delta,
    input  wire logic [pwlg_pkg::LANES-1:0]        lane_on,
    input  wire logic [pwlg_pkg::PROD_W-1:0]       lane_prod [pwlg_pkg::LANES],
    input  wire logic signed [pwlg_pkg::BAL_W-1:0] real_bal,
    input  wire logic signed [pwlg_pkg::BAL_W-1:0] virt_bal,
    input  wire logic [pwlg_pkg::BAND_W-1:0]       zero_band,
    output pwlg_pkg::wallet_upd_t                  upd
);
    import pwlg_pkg::*;

    logic [SUM_W-1:0]         sum;
    logic [COST_W-1:0]        cost;
    logic signed [WIDE_W-1:0] real_diff;
    logic signed [WIDE_W-1:0] virt_diff;
    logic signed [BAL_W-1:0]  real_new;
    logic signed [BAL_W-1:0]  virt_new;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < LANES; k++)
        begin
            sum = sum + SUM_W'(lane_prod[k]);
        end
    end

    assign cost      = sum[SUM_W-1:FRAC_W];
    assign real_diff = WIDE_W'(real_bal) - $signed({{(WIDE_W - COST_W){1'b0}}, cost});
    assign virt_diff = WIDE_W'(virt_bal) - $signed({{(WIDE_W - COST_W){1'b0}}, cost});
    assign real_new  = band_clear(sat_bal(real_diff), zero_band);
    assign virt_new  = band_clear(sat_bal(virt_diff), zero_band);

    always_comb
    begin
        upd.mask     = '0;
        upd.real_bal = real_bal;
        upd.virt_bal = virt_bal;
        upd.shed     = 1'b0;
        case (kind)
            KIND_TIMESTEP:
            begin
                if (real_new[BAL_W-1])
                begin
                    upd.shed = 1'b1;
                end
                else
                begin
                    upd.mask     = FIELD_LOADS'(lane_on);
                    upd.real_bal = real_new;
                    upd.virt_bal = virt_new;
                end
            end
            KIND_DAY_START:
            begin
                upd.real_bal = sat_bal(WIDE_W'(real_bal) + WIDE_W'(real_delta));
                upd.virt_bal = sat_bal(WIDE_W'(virt_bal) + WIDE_W'(virtual_delta));
            end
            default:
            begin
                upd.mask = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/prepaid_wallet_load_gate_top.sv
// Top level of the prepaid wallet load gate: handshake, wallet state and lanes.
`timescale 1ns / 1ps
`default_nettype none

// Prepaid wallet load gate. Each input word is a timestep, a day start or a
// threshold write; every word returns exactly one result word with the load
// actuation mask and both balances after the word. Words flow through two
// stages and one can be accepted every clock while in_stall is low: the first
// stage registers the per-load power-times-rate products, the second decides
// which loads run, sums their cost and updates the wallets, and its output
// register holds the result. out_valid rises when a word moves from the first
// stage into the output register. The wallet and threshold state is updated
// when a word leaves the first stage, so the next word sees it without
// stalling. Configuration writes take effect at the clock edge at which
// cfg_write is high.
module prepaid_wallet_load_gate_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire pwlg_pkg::in_word_t                in_word,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output pwlg_pkg::out_word_t                    out_word,
    input  wire logic                              cfg_write,
    input  wire logic [pwlg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pwlg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pwlg_pkg::*;

`include "prepaid_wallet_load_gate_top_defines.svh"

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    in_word_t                 s1_word_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_word_t                out_word_reg;
    logic signed [BAL_W-1:0]  real_wallet_reg;
    logic signed [BAL_W-1:0]  virt_wallet_reg;
    logic signed [BAL_W-1:0]  thr_reg [LOADS];
    logic [RATE_W-1:0]        rate_reg;
    logic [BAND_W-1:0]        band_reg;

    logic                     out_ready;
    logic                     in_accept;
    logic                     s1_move;
    logic [POW_W-1:0]         in_power [FIELD_LOADS];
    logic [LANES-1:0]         lane_on;
    logic [PROD_W-1:0]        lane_prod [LANES];
    wallet_upd_t              upd;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    assign in_power[0] = in_word.power_0;
    assign in_power[1] = in_word.power_1;
    assign in_power[2] = in_word.power_2;
    assign in_power[3] = in_word.power_3;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        pwlg_lane u_lane (
            .clk        (clk),
            .load       (in_accept),
            .power      (in_power[k]),
            .rate       (rate_reg),
            .demand     (s1_word_reg.demand_mask[k]),
            .threshold  (thr_reg[k]),
            .virt_bal   (virt_wallet_reg),
            .real_pos   (!real_wallet_reg[BAL_W-1] && (real_wallet_reg != '0)),
            .on         (lane_on[k]),
            .gated_prod (lane_prod[k])
        );
    end

    pwlg_merge u_merge (
        .kind          (s1_word_reg.kind),
        .real_delta    (s1_word_reg.real_delta),
        .virtual_delta (s1_word_reg.virtual_delta),
        .lane_on       (lane_on),
        .lane_prod     (lane_prod),
        .real_bal      (real_wallet_reg),
        .virt_bal      (virt_wallet_reg),
        .zero_band     (band_reg),
        .upd           (upd)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            real_wallet_reg <= '0;
            virt_wallet_reg <= '0;
            rate_reg        <= '0;
            band_reg        <= ZERO_BAND_RESET;
            for (int k = 0; k < LOADS; k++)
            begin
                thr_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RATE:      rate_reg <= cfg_data[RATE_W-1:0];
                    REG_ZERO_BAND: band_reg <= cfg_data[BAND_W-1:0];
                    default:       rate_reg <= rate_reg;
                endcase
            end
            if (s1_move)
            begin
                real_wallet_reg <= upd.real_bal;
                virt_wallet_reg <= upd.virt_bal;
                if (s1_word_reg.kind == KIND_SET_THRESHOLD)
                begin
                    for (int k = 0; k < LOADS; k++)
                    begin
                        if (32'(s1_word_reg.load_index) == k)
                        begin
                            thr_reg[k] <= s1_word_reg.threshold_value;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_word_reg <= in_word;
        end
        if (s1_move)
        begin
            out_word_reg.actuation_mask  <= upd.mask;
            out_word_reg.real_balance    <= upd.real_bal;
            out_word_reg.virtual_balance <= upd.virt_bal;
            out_word_reg.shed_all        <= upd.shed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `PWLG_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid_reg, "input stalled with empty stage")
    `PWLG_ASSERT_NOW(a_shed_clears_mask, out_valid_reg && out_word_reg.shed_all,
        out_word_reg.actuation_mask == '0, "shed word reports running loads")
    `PWLG_ASSERT_NOW(a_mask_within_demand, s1_valid_reg,
        (upd.mask & ~s1_word_reg.demand_mask) == '0, "load runs without demand")
    `PWLG_ASSERT_NEXT(a_timestep_keeps_real_nonneg,
        s1_move && (s1_word_reg.kind == KIND_TIMESTEP) && !upd.shed,
        !real_wallet_reg[BAL_W-1], "timestep left real balance negative")

endmodule

`default_nettype wire

### verif/prepaid_wallet_load_gate_top_test.sv
// Self-checking testbench for the prepaid wallet load gate top level.
`timescale 1ns / 1ps

module prepaid_wallet_load_gate_top_test;
    import pwlg_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic signed [BAL_W-1:0] BAL_TOP    = {1'b0, {(BAL_W - 1){1'b1}}};
    localparam logic signed [BAL_W-1:0] BAL_BOTTOM = {1'b1, {(BAL_W - 1){1'b0}}};
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 64;
    localparam int PHASE_WORDS   = 180;
    localparam int MAX_PRINTED   = 200;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_op_t;

    typedef struct {
        row_op_t     op;
        cfg_reg_t    reg_id;
        logic [31:0] reg_val;
        in_word_t    w;
        bit          typed;
        out_word_t   want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the wallet state and registers.
    logic signed [BAL_W-1:0] wallet_real;
    logic signed [BAL_W-1:0] wallet_virt;
    logic signed [BAL_W-1:0] thresholds[LOADS];
    logic [RATE_W-1:0]       rate_reg;
    logic [BAND_W-1:0]       band_reg;

    out_word_t wallet_reports[$];
    plan_row_t plan[$];

    int  mismatches;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_count;
    bit  hold_start;

    prepaid_wallet_load_gate_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [63:0] clamp_bal(input logic signed [63:0] v);
        logic signed [63:0] top;
        logic signed [63:0] bottom;
        top    = BAL_TOP;
        bottom = BAL_BOTTOM;
        if (v > top)
            return top;
        if (v < bottom)
            return bottom;
        return v;
    endfunction

    function automatic logic signed [63:0] snap_band(input logic signed [63:0] v);
        logic signed [63:0] band;
        band = {44'd0, band_reg};
        if (v < 0 && -v < band)
            return 64'sd0;
        return v;
    endfunction

    // Applies one word to the local wallet state and returns the result word it reports.
    function automatic out_word_t next_wallet_report(input in_word_t w);
        out_word_t          r;
        logic [POW_W-1:0]   power[FIELD_LOADS];
        logic [63:0]        cost_sum;
        logic signed [63:0] cost;
        logic signed [63:0] old_real;
        logic signed [63:0] old_virt;
        logic signed [63:0] new_real;
        logic signed [63:0] new_virt;
        logic signed [63:0] delta;
        logic [FIELD_LOADS-1:0] mask;
        logic               shed;
        power    = '{w.power_0, w.power_1, w.power_2, w.power_3};
        mask     = '0;
        shed     = 1'b0;
        old_real = wallet_real;
        old_virt = wallet_virt;
        case (w.kind)
            KIND_SET_THRESHOLD:
            begin
                if (w.load_index < LOADS)
                    thresholds[w.load_index] = w.threshold_value;
            end
            KIND_DAY_START:
            begin
                delta       = 64'(w.real_delta);
                wallet_real = BAL_W'(clamp_bal(old_real + delta));
                delta       = 64'(w.virtual_delta);
                wallet_virt = BAL_W'(clamp_bal(old_virt + delta));
            end
            KIND_TIMESTEP:
            begin
                cost_sum = '0;
                for (int k = 0; k < LANES; k++)
                begin
                    if (w.demand_mask[k] && wallet_virt >= thresholds[k] && wallet_real > 0)
                    begin
                        mask[k]  = 1'b1;
                        cost_sum = cost_sum + 64'(power[k]) * 64'(rate_reg);
                    end
                end
                cost     = $signed(cost_sum >> FRAC_W);
                new_real = snap_band(clamp_bal(old_real - cost));
                new_virt = snap_band(clamp_bal(old_virt - cost));
                if (new_real < 0)
                begin
                    mask = '0;
                    shed = 1'b1;
                end
                else
                begin
                    wallet_real = new_real[BAL_W-1:0];
                    wallet_virt = new_virt[BAL_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        r.actuation_mask  = mask;
        r.real_balance    = wallet_real;
        r.virtual_balance = wallet_virt;
        r.shed_all        = shed;
        return r;
    endfunction

    function automatic in_word_t word_of(input logic [1:0] kind, input logic [1:0] idx,
                                         input logic signed [BAL_W-1:0] thr,
                                         input logic signed [BAL_W-1:0] rd,
                                         input logic signed [BAL_W-1:0] vd,
                                         input logic [3:0] dm, input logic [15:0] p0,
                                         input logic [15:0] p1, input logic [15:0] p2,
                                         input logic [15:0] p3);
        in_word_t w;
        w.kind            = kind;
        w.load_index      = idx;
        w.threshold_value = thr;
        w.real_delta      = rd;
        w.virtual_delta   = vd;
        w.demand_mask     = dm;
        w.power_0         = p0;
        w.power_1         = p1;
        w.power_2         = p2;
        w.power_3         = p3;
        return w;
    endfunction

    function automatic out_word_t report_of(input logic [3:0] mask,
                                            input logic signed [BAL_W-1:0] rb,
                                            input logic signed [BAL_W-1:0] vb,
                                            input logic shed);
        out_word_t r;
        r.actuation_mask  = mask;
        r.real_balance    = rb;
        r.virtual_balance = vb;
        r.shed_all        = shed;
        return r;
    endfunction

    function automatic plan_row_t word_row(input in_word_t w, input bit typed,
                                           input out_word_t want);
        plan_row_t row;
        row.op      = ROW_WORD;
        row.reg_id  = REG_RATE;
        row.reg_val = '0;
        row.w       = w;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input cfg_reg_t id, input logic [31:0] val);
        plan_row_t row;
        row.op      = ROW_REG;
        row.reg_id  = id;
        row.reg_val = val;
        row.w       = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    // Signed value spread over every magnitude, with the extremes mixed in.
    function automatic logic signed [BAL_W-1:0] spread_value(input int up_pct);
        logic [63:0]      raw;
        logic [BAL_W-1:0] mag;
        int               span;
        int               pick;
        pick = $urandom_range(0, 99);
        raw  = {$urandom, $urandom};
        if (pick < 4)
            return BAL_TOP;
        if (pick < 8)
            return BAL_BOTTOM;
        if (pick < 16)
            return raw[BAL_W-1:0];
        span = $urandom_range(1, BAL_W - 1);
        mag  = raw[BAL_W-1:0] & ((40'd1 << span) - 40'd1);
        if ($urandom_range(0, 99) < up_pct)
            return mag;
        return -mag;
    endfunction

    function automatic logic [POW_W-1:0] shaped_power();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        return POW_W'($urandom);
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int       pick;
        w    = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            w.kind    = KIND_TIMESTEP;
            w.power_0 = shaped_power();
            w.power_1 = shaped_power();
            w.power_2 = shaped_power();
            w.power_3 = shaped_power();
        end
        else if (pick < 80)
        begin
            w.kind          = KIND_DAY_START;
            w.real_delta    = spread_value(80);
            w.virtual_delta = spread_value(60);
        end
        else if (pick < 95)
        begin
            w.kind            = KIND_SET_THRESHOLD;
            w.threshold_value = spread_value(50);
        end
        else
        begin
            w.kind = KIND_UNUSED;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [BAL_W-1:0] got,
                                   input logic [BAL_W-1:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offers one word and holds it until the gate takes it.
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t predicted;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = next_wallet_report(w);
        wallet_reports.push_back(typed ? want : predicted);
    endtask

    task automatic sender_gap();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic settle();
        while (wallet_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_register(input cfg_reg_t id, input logic [31:0] val);
        in_valid <= 1'b0;
        settle();
        cfg_write <= 1'b1;
        cfg_index <= id;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (id)
            REG_RATE:      rate_reg = val;
            REG_ZERO_BAND: band_reg = val[BAND_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    // Receiver side: random stalls, or one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_count = HOLD_CYCLES;
        end
        if (hold_count > 0)
        begin
            out_stall <= 1'b1;
            hold_count = hold_count - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (wallet_reports.size() == 0)
            begin
                report_mismatch("word with nothing expected", out_word.real_balance, '0);
            end
            else
            begin
                want = wallet_reports.pop_front();
                if (out_word.actuation_mask !== want.actuation_mask)
                    report_mismatch("actuation_mask", BAL_W'(out_word.actuation_mask),
                                    BAL_W'(want.actuation_mask));
                if (out_word.real_balance !== want.real_balance)
                    report_mismatch("real_balance", out_word.real_balance, want.real_balance);
                if (out_word.virtual_balance !== want.virtual_balance)
                    report_mismatch("virtual_balance", out_word.virtual_balance,
                                    want.virtual_balance);
                if (out_word.shed_all !== want.shed_all)
                    report_mismatch("shed_all", BAL_W'(out_word.shed_all),
                                    BAL_W'(want.shed_all));
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] rate_val;
        logic [31:0] band_val;
        out_word_t   zero_report;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        out_stall     = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_count    = 0;
        hold_start    = 1'b0;
        wallet_real   = '0;
        wallet_virt   = '0;
        for (int k = 0; k < LOADS; k++)
            thresholds[k] = '0;
        rate_reg    = '0;
        band_reg    = ZERO_BAND_RESET;
        zero_report = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset state, saturation, the zero band, shedding and extremes.
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'hF,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                                1'b1, zero_report));
        plan.push_back(word_row(word_of(KIND_UNUSED, 2'd3, BAL_TOP, BAL_TOP, BAL_BOTTOM, 4'hF,
                                        16'hFFFF, 16'h0, 16'hFFFF, 16'h0),
                                1'b1, zero_report));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd0, '0, BAL_TOP, BAL_BOTTOM, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0),
                                1'b1, report_of(4'h0, BAL_TOP, BAL_BOTTOM, 1'b0)));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd1, '0, BAL_TOP, BAL_BOTTOM, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0),
                                1'b1, report_of(4'h0, BAL_TOP, BAL_BOTTOM, 1'b0)));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd2, '0, BAL_BOTTOM, BAL_TOP, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0),
                                1'b1, report_of(4'h0, -40'sd1, -40'sd1, 1'b0)));
        // A real balance of minus one lies inside the reset band and snaps to zero.
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'hF,
                                        16'h1, 16'h1, 16'h1, 16'h1),
                                1'b1, zero_report));
        plan.push_back(word_row(word_of(KIND_SET_THRESHOLD, 2'd3, BAL_BOTTOM, '0, '0, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0),
                                1'b1, zero_report));
        plan.push_back(word_row(word_of(KIND_SET_THRESHOLD, 2'd0, BAL_TOP, '0, '0, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0),
                                1'b1, zero_report));
        plan.push_back(reg_row(REG_ZERO_BAND, 32'd0));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd0, '0, -40'sd5, 40'sd7, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0),
                                1'b1, report_of(4'h0, -40'sd5, 40'sd7, 1'b0)));
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'hF,
                                        16'h10, 16'h10, 16'h10, 16'h10),
                                1'b1, report_of(4'h0, -40'sd5, 40'sd7, 1'b1)));
        plan.push_back(reg_row(REG_RATE, 32'h0001_0000));
        plan.push_back(reg_row(REG_ZERO_BAND, 32'd1000000));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd0, '0, 40'sd1005, 40'sd493, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0), 1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_SET_THRESHOLD, 2'd1, 40'sd600, '0, '0, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0), 1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'hF,
                                        16'd100, 16'd100, 16'd100, 16'd100),
                                1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'hF,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                                1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd0, '0, 40'sd100, '0, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0), 1'b0, zero_report));
        plan.push_back(reg_row(REG_ZERO_BAND, 32'd0));
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'h8,
                                        16'h0, 16'h0, 16'h0, 16'hFFFF), 1'b0, zero_report));
        plan.push_back(reg_row(REG_RATE, 32'hFFFF_FFFF));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd0, '0, BAL_TOP, BAL_TOP, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0), 1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'hF,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                                1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd0, '0, '0, BAL_BOTTOM, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0), 1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_DAY_START, 2'd0, '0, '0, BAL_BOTTOM, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0), 1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_SET_THRESHOLD, 2'd2, BAL_BOTTOM, '0, '0, 4'h0,
                                        16'h0, 16'h0, 16'h0, 16'h0), 1'b0, zero_report));
        // The virtual balance sits at its floor, so the cost saturates it there.
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'h4,
                                        16'h0, 16'h0, 16'hFFFF, 16'h0), 1'b0, zero_report));
        plan.push_back(word_row(word_of(KIND_TIMESTEP, 2'd0, '0, '0, '0, 4'h0,
                                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                                1'b0, zero_report));

        foreach (plan[i])
        begin
            if (plan[i].op == ROW_REG)
                set_register(plan[i].reg_id, plan[i].reg_val);
            else
                send_word(plan[i].w, plan[i].typed, plan[i].want);
        end
        in_valid <= 1'b0;
        settle();

        // Random part: six register settings over three idling patterns.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0:
                begin
                    rate_val = 32'h0001_0000;
                    band_val = 32'd125;
                end
                1:
                begin
                    rate_val = 32'hFFFF_FFFF;
                    band_val = 32'd0;
                end
                2:
                begin
                    rate_val = 32'd0;
                    band_val = 32'd1000000;
                end
                3:
                begin
                    rate_val = $urandom_range(1, 32'h00FF_FFFF);
                    band_val = $urandom_range(0, 1000000);
                end
                4:
                begin
                    rate_val = $urandom;
                    band_val = $urandom_range(0, 1000000);
                end
                default:
                begin
                    rate_val = $urandom_range(0, 32'h0000_FFFF);
                    band_val = $urandom_range(0, 1000000);
                end
            endcase
            set_register(REG_RATE, rate_val);
            set_register(REG_ZERO_BAND, band_val);
            // With no sender gaps, a long receiver hold-off backs the pipeline up.
            if (phase == 4)
                hold_start = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                sender_gap();
                send_word(random_word(), 1'b0, zero_report);
            end
            in_valid <= 1'b0;
            settle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && wallet_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### prepaid_wallet_load_gate_top.f
+incdir+rtl
rtl/pwlg_pkg.sv
rtl/pwlg_lane.sv
rtl/pwlg_merge.sv
rtl/prepaid_wallet_load_gate_top.sv
verif/prepaid_wallet_load_gate_top_test.sv
